### rtl/tlbw_pkg.sv
// Package for the TLB and page-walk block: default sizes, fixed field
// widths and the state type of the back end. No dependencies.
`default_nettype none

package tlbw_pkg;

  localparam int OFFSET_BITS_DEF = 12;
  localparam int DIR_BITS_DEF    = 10;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int FRAME_COUNT_DEF = 256;
  localparam int TLB_ENTRIES_DEF = 16;

  localparam int VA_W  = 32;
  localparam int PA_W  = 20;
  localparam int CNT_W = 32;
  localparam int AGE_W = 32;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_PT,
    S_SCAN,
    S_FILL,
    S_DONE
  } back_state_t;

endpackage

`default_nettype wire

### rtl/tlb_lru_two_level_page_walk.sv
// Top level of the address translation block: front end with queue and
// back end with TLB and page table. Uses tlbw_pkg, tlbw_front, tlbw_back.
//
// Each transaction carries one virtual address and yields one translation.
// After reset the block sweeps all 2^(DIR_BITS+TABLE_BITS) page-table entries
// (1048576 by default), one entry per cycle, and accepts nothing until that
// pass ends. A TLB hit passes through the lookup and done states of the back
// end. A miss also reads the page table; it fills a free TLB entry directly
// while one is left, and once all entries are valid an age scan that visits
// one TLB entry per cycle first finds the least recently used victim. The
// page-table read is one synchronous memory access.
`default_nettype none

module tlb_lru_two_level_page_walk #(
  parameter int OFFSET_BITS = tlbw_pkg::OFFSET_BITS_DEF,
  parameter int DIR_BITS    = tlbw_pkg::DIR_BITS_DEF,
  parameter int TABLE_BITS  = tlbw_pkg::TABLE_BITS_DEF,
  parameter int FRAME_COUNT = tlbw_pkg::FRAME_COUNT_DEF,
  parameter int TLB_ENTRIES = tlbw_pkg::TLB_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tlbw_pkg::VA_W-1:0]   in_virt_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tlbw_pkg::PA_W-1:0]        out_phys_addr,
  output logic                             out_tlb_hit,
  output logic                             out_page_fault,
  output logic [tlbw_pkg::CNT_W-1:0]       out_hit_total,
  output logic [tlbw_pkg::CNT_W-1:0]       out_fault_total
);
  import tlbw_pkg::*;

  localparam int VPN_BITS = DIR_BITS + TABLE_BITS;

  logic                   q_valid, q_pop, busy_clear;
  logic [VPN_BITS-1:0]    q_vpn;
  logic [OFFSET_BITS-1:0] q_offset;

  tlbw_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .VPN_BITS   (VPN_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_virt_addr(in_virt_addr),
    .busy_clear  (busy_clear),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_vpn       (q_vpn),
    .q_offset    (q_offset)
  );

  tlbw_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .VPN_BITS   (VPN_BITS),
    .FRAME_COUNT(FRAME_COUNT),
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_vpn          (q_vpn),
    .q_offset       (q_offset),
    .busy_clear     (busy_clear),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_phys_addr  (out_phys_addr),
    .out_tlb_hit    (out_tlb_hit),
    .out_page_fault (out_page_fault),
    .out_hit_total  (out_hit_total),
    .out_fault_total(out_fault_total)
  );

endmodule

`default_nettype wire

### rtl/tlbw_front.sv
// Front end: accepts virtual addresses, splits them into page number and
// offset and holds them in a two-entry queue. Uses tlbw_pkg.
`default_nettype none

module tlbw_front #(
  parameter int OFFSET_BITS = tlbw_pkg::OFFSET_BITS_DEF,
  parameter int VPN_BITS    = tlbw_pkg::DIR_BITS_DEF + tlbw_pkg::TABLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tlbw_pkg::VA_W-1:0]   in_virt_addr,
  input  wire logic                        busy_clear,
  output logic                             q_valid,
  input  wire logic                        q_pop,
  output logic [VPN_BITS-1:0]              q_vpn,
  output logic [OFFSET_BITS-1:0]           q_offset
);
  import tlbw_pkg::*;

  localparam int SPLIT_W = OFFSET_BITS + VPN_BITS;

  logic [SPLIT_W-1:0]     va_ext;
  logic [VPN_BITS-1:0]    vpn_r [2];
  logic [OFFSET_BITS-1:0] off_r [2];
  logic                   wp_r, rp_r;
  logic [1:0]             cnt_r;
  logic                   push;

  assign va_ext   = SPLIT_W'(in_virt_addr);
  assign in_stall = busy_clear || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_vpn    = vpn_r[rp_r];
  assign q_offset = off_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      vpn_r[wp_r] <= va_ext[SPLIT_W-1:OFFSET_BITS];
      off_r[wp_r] <= va_ext[OFFSET_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tlbw_back.sv
// Back end: TLB with LRU ages, page-table memory with its clearing pass,
// frame allocation, totals and the output register. Uses tlbw_pkg.
`default_nettype none

module tlbw_back #(
  parameter int OFFSET_BITS = tlbw_pkg::OFFSET_BITS_DEF,
  parameter int VPN_BITS    = tlbw_pkg::DIR_BITS_DEF + tlbw_pkg::TABLE_BITS_DEF,
  parameter int FRAME_COUNT = tlbw_pkg::FRAME_COUNT_DEF,
  parameter int TLB_ENTRIES = tlbw_pkg::TLB_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire logic [VPN_BITS-1:0]          q_vpn,
  input  wire logic [OFFSET_BITS-1:0]       q_offset,
  output logic                              busy_clear,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tlbw_pkg::PA_W-1:0]         out_phys_addr,
  output logic                              out_tlb_hit,
  output logic                              out_page_fault,
  output logic [tlbw_pkg::CNT_W-1:0]        out_hit_total,
  output logic [tlbw_pkg::CNT_W-1:0]        out_fault_total
);
  import tlbw_pkg::*;

  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int IDX_W      = $clog2(TLB_ENTRIES);
  localparam int PT_DEPTH   = 1 << VPN_BITS;
  localparam int FULL_W     = (FRAME_BITS + OFFSET_BITS > PA_W) ?
                              FRAME_BITS + OFFSET_BITS : PA_W;
  localparam logic [FRAME_BITS-1:0] FRAME_LAST = FRAME_BITS'(FRAME_COUNT - 1);
  localparam logic [IDX_W-1:0]      IDX_LAST   = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [VPN_BITS-1:0]   CLR_LAST   = VPN_BITS'(PT_DEPTH - 1);
  localparam logic [AGE_W-1:0]      AGE_SAT    = '1;
  localparam logic [CNT_W-1:0]      CNT_SAT    = '1;

  back_state_t state_r, state_nxt;

  logic [VPN_BITS-1:0]    tag_r   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  tframe_r[TLB_ENTRIES];
  logic [AGE_W-1:0]       age_r   [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_r;

  logic [FRAME_BITS:0]    pt_mem [PT_DEPTH];
  logic [FRAME_BITS:0]    pt_rd_r;
  logic                   pt_we;
  logic [VPN_BITS-1:0]    pt_wa;
  logic [FRAME_BITS:0]    pt_wd;

  logic [VPN_BITS-1:0]    vpn_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [FRAME_BITS-1:0]  frame_r;
  logic                   hit_r, fault_r;
  logic [IDX_W-1:0]       victim_r, scan_r;
  logic [AGE_W-1:0]       best_age_r;
  logic [VPN_BITS-1:0]    clr_r;
  logic [FRAME_BITS-1:0]  fcnt_r;
  logic [CNT_W-1:0]       hits_r, faults_r;

  logic                   match_any, inv_any;
  logic [IDX_W-1:0]       match_idx, inv_idx;
  logic                   do_pop, do_hit, do_pt, do_fill, do_out, out_free;
  logic [FULL_W-1:0]      pa_full;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    inv_any   = 1'b0;
    inv_idx   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == vpn_r)) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        inv_any = 1'b1;
        inv_idx = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = match_any ? S_DONE : S_PT;
      S_PT:    state_nxt = inv_any ? S_FILL : S_SCAN;
      S_SCAN:  if (scan_r == IDX_LAST) state_nxt = S_FILL;
      S_FILL:  state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    busy_clear = (state_r == S_CLEAR);
    do_pop     = (state_r == S_IDLE) && q_valid;
    do_hit     = (state_r == S_LOOK) && match_any;
    do_pt      = (state_r == S_PT);
    do_fill    = (state_r == S_FILL);
    do_out     = (state_r == S_DONE) && out_free;
    q_pop      = do_pop;
    pt_we      = busy_clear || (do_pt && !pt_rd_r[FRAME_BITS]);
    pt_wa      = busy_clear ? clr_r : vpn_r;
    pt_wd      = busy_clear ? '0 : {1'b1, fcnt_r};
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_rd_r <= pt_mem[vpn_r];
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      vpn_r <= q_vpn;
      off_r <= q_offset;
    end
    if (do_hit) begin
      frame_r <= tframe_r[match_idx];
    end
    if (do_pt) begin
      frame_r    <= pt_rd_r[FRAME_BITS] ? pt_rd_r[FRAME_BITS-1:0] : fcnt_r;
      fault_r    <= !pt_rd_r[FRAME_BITS];
      victim_r   <= inv_any ? inv_idx : '0;
      scan_r     <= IDX_W'(1);
      best_age_r <= age_r[0];
    end
    if (state_r == S_LOOK) begin
      hit_r   <= match_any;
      fault_r <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (age_r[scan_r] > best_age_r) begin
        victim_r   <= scan_r;
        best_age_r <= age_r[scan_r];
      end
      scan_r <= scan_r + IDX_W'(1);
    end
    if (do_fill) begin
      tag_r[victim_r]    <= vpn_r;
      tframe_r[victim_r] <= frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      valid_r  <= '0;
      fcnt_r   <= '0;
      hits_r   <= '0;
      faults_r <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (busy_clear) begin
        clr_r <= clr_r + VPN_BITS'(1);
      end
      if (do_pop) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (valid_r[i] && (age_r[i] != AGE_SAT)) begin
            age_r[i] <= age_r[i] + AGE_W'(1);
          end
        end
      end
      if (do_hit) begin
        age_r[match_idx] <= '0;
        if (hits_r != CNT_SAT) begin
          hits_r <= hits_r + CNT_W'(1);
        end
      end
      if (do_pt && !pt_rd_r[FRAME_BITS]) begin
        fcnt_r <= (fcnt_r == FRAME_LAST) ? '0 : fcnt_r + FRAME_BITS'(1);
        if (faults_r != CNT_SAT) begin
          faults_r <= faults_r + CNT_W'(1);
        end
      end
      if (do_fill) begin
        age_r[victim_r]   <= '0;
        valid_r[victim_r] <= 1'b1;
      end
    end
  end

  assign pa_full = FULL_W'({frame_r, off_r});

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_phys_addr   <= pa_full[PA_W-1:0];
      out_tlb_hit     <= hit_r;
      out_page_fault  <= fault_r;
      out_hit_total   <= hits_r;
      out_fault_total <= faults_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (do_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
